[hw/rtl/sbce_pkg.sv]
// Package: opcodes, error codes and sizes of the execute block.
`default_nettype none
package sbce_pkg;
   localparam int DataBytes  = 65536;
   localparam int StackDepth = 256;
   localparam int FrameDepth = 16;
   localparam int DataAw  = $clog2(DataBytes);
   localparam int StackAw = $clog2(StackDepth);
   localparam int FrameAw = $clog2(FrameDepth);

   typedef enum logic [4:0] {
      OP_HLT, OP_JMP, OP_CJMP, OP_OJMP, OP_CALL, OP_RET, OP_PUSH, OP_POP,
      OP_LOADB, OP_LOADW, OP_STOREB, OP_STOREW, OP_LOADI, OP_NOP, OP_IN, OP_OUT,
      OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_MUL, OP_DIV, OP_AND, OP_OR,
      OP_XOR, OP_NOT, OP_SAL, OP_SAR, OP_EQU, OP_LT, OP_LTE, OP_NOTC
   } opcode_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0, ERR_DIV_ZERO = 3'd1, ERR_POP_R0 = 3'd2,
      ERR_STACK = 3'd3, ERR_FRAME = 3'd4
   } error_type;
endpackage
`default_nettype wire

[hw/rtl/sixteen_bit_cpu_execute.sv]
// Top level: execute stage with register file, data memory and stacks.
`default_nettype none
// One request executes one decoded instruction and gives one response.
// Simple instructions pass through accept, memory read, execute and respond;
// LOADW and STOREW add a second memory step, set by the single byte port
// of the data memory; DIV adds a divider that shifts in one quotient bit a
// cycle and then writes the quotient back; CALL and RET add a sweep that moves
// the eight registers one a cycle through the frame memory port and lands the
// last read, then a step that updates the frame pointer and PC. A divide by
// zero or a frame stack error responds without the divider or the sweep.
// Data memory, value stack and frame memories are not cleared after reset.
// A new request is taken as soon as the response register is free.
module sixteen_bit_cpu_execute (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_opcode,
   input  wire logic [2:0]  req_dest_reg,
   input  wire logic [2:0]  req_src_reg_a,
   input  wire logic [2:0]  req_src_reg_b,
   input  wire logic signed [15:0] req_immediate,
   input  wire logic [23:0] req_address,
   input  wire logic [7:0]  req_in_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [23:0]      rsp_next_pc,
   output logic             rsp_halted,
   output logic             rsp_out_valid,
   output logic [7:0]       rsp_out_char,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_overflow_out,
   output logic             rsp_compare_out
);
   localparam int DAw = sbce_pkg::DataAw;
   localparam int SAw = sbce_pkg::StackAw;
   localparam int FAw = sbce_pkg::FrameAw;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_EXEC, S_MEM2, S_DIV, S_FRAME, S_FRAME_END, S_RESP
   } state_type;

   // memories
   logic [7:0]  dmem [sbce_pkg::DataBytes];
   logic [15:0] vstack [sbce_pkg::StackDepth];
   logic [15:0] fregs [sbce_pkg::FrameDepth*8];
   logic [25:0] fmeta [sbce_pkg::FrameDepth];   // {flags, return pc}

   state_type state_ff;
   logic [15:0] regs_ff [8];
   logic [23:0] pc_ff;
   logic ovf_ff, cmp_ff;
   logic [SAw:0] sp_ff;
   logic [FAw:0] fp_ff;

   sbce_pkg::opcode_type op_ff;
   logic [2:0]  d_ff;
   logic [15:0] imm_ff;
   logic [23:0] addr_ff;
   logic [7:0]  ch_ff;
   logic [15:0] rd_ff, ra_ff, rb_ff;
   logic [DAw-1:0] ea_ff;
   logic [7:0]  dlo_ff;

   // memory read data
   logic [7:0]  drd_ff;
   logic [15:0] vrd_ff, frd_ff;
   logic [25:0] mrd_ff;

   // divider
   logic [4:0]  cnt_ff;
   logic [15:0] quo_ff, rem_ff, dvs_ff;
   logic        qneg_ff;
   // frame sweep
   logic [3:0]  fi_ff;

   logic [23:0] npc_ff;
   logic halt_ff, outv_ff;
   logic [7:0] outc_ff;
   logic [2:0] err_ff;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_next_pc      = npc_ff;
   assign rsp_halted       = halt_ff;
   assign rsp_out_valid    = outv_ff;
   assign rsp_out_char     = outc_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_overflow_out = ovf_ff;
   assign rsp_compare_out  = cmp_ff;

   // effective address from request and signed r7
   logic [23:0] ea_full;
   assign ea_full = req_address + {{8{regs_ff[7][15]}}, regs_ff[7]};

   logic [23:0] pc4;
   assign pc4 = pc_ff + 24'd4;

   // execute arithmetic on registered operands
   logic signed [16:0] add_x, sub_x, addi_x, subi_x;
   logic signed [31:0] mul_x;
   logic [15:0] sal_r, sar_r;
   logic        big_cnt;
   assign add_x  = $signed({ra_ff[15], ra_ff}) + $signed({rb_ff[15], rb_ff});
   assign sub_x  = $signed({ra_ff[15], ra_ff}) - $signed({rb_ff[15], rb_ff});
   assign addi_x = $signed({rd_ff[15], rd_ff}) + $signed({imm_ff[15], imm_ff});
   assign subi_x = $signed({rd_ff[15], rd_ff}) - $signed({imm_ff[15], imm_ff});
   assign mul_x  = $signed(ra_ff) * $signed(rb_ff);
   assign big_cnt = |rb_ff[15:4];
   assign sal_r  = big_cnt ? 16'd0 : (ra_ff << rb_ff[3:0]);
   assign sar_r  = $signed(ra_ff) >>> (big_cnt ? 4'd15 : rb_ff[3:0]);

   // divider step: restoring, one bit a cycle on magnitudes
   logic [16:0] trial;
   assign trial = {rem_ff, quo_ff[15]} - {1'b0, dvs_ff};

   logic [15:0] abs_a, abs_b;
   assign abs_a = ra_ff[15] ? (16'd0 - ra_ff) : ra_ff;
   assign abs_b = rb_ff[15] ? (16'd0 - rb_ff) : rb_ff;

   // frame address of the current sweep slot
   logic [FAw-1:0] fslot;
   assign fslot = (op_ff == sbce_pkg::OP_CALL) ? fp_ff[FAw-1:0]
                                                : fp_ff[FAw-1:0] - 1'b1;

   // memory ports
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         drd_ff <= dmem[ea_full[DAw-1:0]];
         vrd_ff <= vstack[sp_ff[SAw-1:0] - 1'b1];
      end else if (state_ff == S_EXEC) begin
         drd_ff <= dmem[ea_ff + 1'b1];
      end
      if (state_ff == S_EXEC && (op_ff == sbce_pkg::OP_STOREB ||
                                 op_ff == sbce_pkg::OP_STOREW))
         dmem[ea_ff] <= rd_ff[7:0];
      if (state_ff == S_MEM2 && op_ff == sbce_pkg::OP_STOREW)
         dmem[ea_ff + 1'b1] <= rd_ff[15:8];
      if (state_ff == S_EXEC && op_ff == sbce_pkg::OP_PUSH && !sp_ff[SAw])
         vstack[sp_ff[SAw-1:0]] <= rd_ff;
      if (state_ff == S_FRAME && op_ff == sbce_pkg::OP_CALL && !fi_ff[3])
         fregs[{fslot, fi_ff[2:0]}] <= regs_ff[fi_ff[2:0]];
      frd_ff <= fregs[{fslot, fi_ff[2:0]}];
      if (state_ff == S_FRAME && op_ff == sbce_pkg::OP_CALL && fi_ff == 4'd0)
         fmeta[fslot] <= {cmp_ff, ovf_ff, pc4};
      mrd_ff <= fmeta[fslot];
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
         pc_ff <= '0; ovf_ff <= 1'b0; cmp_ff <= 1'b0;
         sp_ff <= '0; fp_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff   <= sbce_pkg::opcode_type'(req_opcode);
                  d_ff    <= req_dest_reg;
                  imm_ff  <= req_immediate;
                  addr_ff <= req_address;
                  ch_ff   <= req_in_char;
                  rd_ff   <= regs_ff[req_dest_reg];
                  ra_ff   <= regs_ff[req_src_reg_a];
                  rb_ff   <= regs_ff[req_src_reg_b];
                  ea_ff   <= ea_full[DAw-1:0];
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               // memory data lands; set up the response and the divider
               npc_ff  <= pc4;
               halt_ff <= 1'b0;
               outv_ff <= 1'b0;
               outc_ff <= 8'd0;
               err_ff  <= sbce_pkg::ERR_NONE;
               fi_ff   <= 4'd0;
               cnt_ff  <= 5'd0;
               quo_ff  <= abs_a;
               rem_ff  <= 16'd0;
               dvs_ff  <= abs_b;
               qneg_ff <= ra_ff[15] ^ rb_ff[15];
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_RESP;
               dlo_ff <= drd_ff;
               unique case (op_ff)
                  sbce_pkg::OP_HLT:  halt_ff <= 1'b1;
                  sbce_pkg::OP_JMP:  npc_ff <= addr_ff;
                  sbce_pkg::OP_CJMP: if (cmp_ff) npc_ff <= addr_ff;
                  sbce_pkg::OP_OJMP: if (ovf_ff) npc_ff <= addr_ff;
                  sbce_pkg::OP_CALL: begin
                     if (fp_ff[FAw]) begin
                        err_ff <= sbce_pkg::ERR_FRAME; halt_ff <= 1'b1;
                     end else state_ff <= S_FRAME;
                  end
                  sbce_pkg::OP_RET: begin
                     if (fp_ff == '0) begin
                        err_ff <= sbce_pkg::ERR_FRAME; halt_ff <= 1'b1;
                     end else state_ff <= S_FRAME;
                  end
                  sbce_pkg::OP_PUSH: begin
                     if (sp_ff[SAw]) begin
                        err_ff <= sbce_pkg::ERR_STACK; halt_ff <= 1'b1;
                     end else sp_ff <= sp_ff + 1'b1;
                  end
                  sbce_pkg::OP_POP: begin
                     if (d_ff == 3'd0) begin
                        err_ff <= sbce_pkg::ERR_POP_R0; halt_ff <= 1'b1;
                     end else if (sp_ff == '0) begin
                        err_ff <= sbce_pkg::ERR_STACK; halt_ff <= 1'b1;
                     end else begin
                        sp_ff <= sp_ff - 1'b1;
                        regs_ff[d_ff] <= vrd_ff;
                     end
                  end
                  sbce_pkg::OP_LOADB: regs_ff[d_ff] <= {{8{drd_ff[7]}}, drd_ff};
                  sbce_pkg::OP_LOADW, sbce_pkg::OP_STOREW: state_ff <= S_MEM2;
                  sbce_pkg::OP_STOREB, sbce_pkg::OP_NOP: ;
                  sbce_pkg::OP_LOADI: regs_ff[d_ff] <= imm_ff;
                  sbce_pkg::OP_IN:    regs_ff[d_ff] <= {8'd0, ch_ff};
                  sbce_pkg::OP_OUT: begin
                     outv_ff <= 1'b1; outc_ff <= rd_ff[7:0];
                  end
                  sbce_pkg::OP_ADD: begin
                     regs_ff[d_ff] <= add_x[15:0]; ovf_ff <= add_x[16] ^ add_x[15];
                  end
                  sbce_pkg::OP_ADDI: begin
                     regs_ff[d_ff] <= addi_x[15:0]; ovf_ff <= addi_x[16] ^ addi_x[15];
                  end
                  sbce_pkg::OP_SUB: begin
                     regs_ff[d_ff] <= sub_x[15:0]; ovf_ff <= sub_x[16] ^ sub_x[15];
                  end
                  sbce_pkg::OP_SUBI: begin
                     regs_ff[d_ff] <= subi_x[15:0]; ovf_ff <= subi_x[16] ^ subi_x[15];
                  end
                  sbce_pkg::OP_MUL: begin
                     regs_ff[d_ff] <= mul_x[15:0];
                     ovf_ff <= (mul_x[31:15] != {17{1'b0}}) &&
                               (mul_x[31:15] != {17{1'b1}});
                  end
                  sbce_pkg::OP_DIV: begin
                     if (rb_ff == 16'd0) begin
                        err_ff <= sbce_pkg::ERR_DIV_ZERO; halt_ff <= 1'b1;
                     end else state_ff <= S_DIV;
                  end
                  sbce_pkg::OP_AND: regs_ff[d_ff] <= ra_ff & rb_ff;
                  sbce_pkg::OP_OR:  regs_ff[d_ff] <= ra_ff | rb_ff;
                  sbce_pkg::OP_XOR: regs_ff[d_ff] <= ra_ff ^ rb_ff;
                  sbce_pkg::OP_NOT: regs_ff[d_ff] <= ~ra_ff;
                  sbce_pkg::OP_SAL: regs_ff[d_ff] <= sal_r;
                  sbce_pkg::OP_SAR: regs_ff[d_ff] <= sar_r;
                  sbce_pkg::OP_EQU: cmp_ff <= (rd_ff == ra_ff);
                  sbce_pkg::OP_LT:  cmp_ff <= ($signed(rd_ff) < $signed(ra_ff));
                  sbce_pkg::OP_LTE: cmp_ff <= ($signed(rd_ff) <= $signed(ra_ff));
                  sbce_pkg::OP_NOTC: cmp_ff <= ~cmp_ff;
                  default: ;
               endcase
            end
            S_MEM2: begin
               // second byte of a word access
               if (op_ff == sbce_pkg::OP_LOADW) regs_ff[d_ff] <= {drd_ff, dlo_ff};
               state_ff <= S_RESP;
            end
            S_DIV: begin
               // shift one quotient bit in
               if (!trial[16]) begin
                  rem_ff <= trial[15:0];
                  quo_ff <= {quo_ff[14:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[14:0], quo_ff[15]};
                  quo_ff <= {quo_ff[14:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd16) begin
                  regs_ff[d_ff] <= qneg_ff ? (16'd0 - quo_ff) : quo_ff;
                  state_ff <= S_RESP;
               end
            end
            S_FRAME: begin
               // one register a cycle; RET reads trail the address by one slot
               fi_ff <= fi_ff + 1'b1;
               if (op_ff == sbce_pkg::OP_RET && fi_ff != 4'd0)
                  regs_ff[fi_ff[2:0] - 1'b1] <= frd_ff;
               if (fi_ff == 4'd8) state_ff <= S_FRAME_END;
            end
            S_FRAME_END: begin
               if (op_ff == sbce_pkg::OP_CALL) begin
                  fp_ff  <= fp_ff + 1'b1;
                  npc_ff <= addr_ff;
               end else begin
                  fp_ff  <= fp_ff - 1'b1;
                  npc_ff <= mrd_ff[23:0];
                  ovf_ff <= mrd_ff[24];
                  cmp_ff <= mrd_ff[25];
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  pc_ff <= npc_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[tb/sv/sixteen_bit_cpu_execute_checker.sv]
// Checker: predicts each response of the execute stage and compares it field by field.
`default_nettype none
module sixteen_bit_cpu_execute_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [4:0]  req_opcode,
   input  wire logic [2:0]  req_dest_reg,
   input  wire logic [2:0]  req_src_reg_a,
   input  wire logic [2:0]  req_src_reg_b,
   input  wire logic [15:0] req_immediate,
   input  wire logic [23:0] req_address,
   input  wire logic [7:0]  req_in_char,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [23:0] rsp_next_pc,
   input  wire logic        rsp_halted,
   input  wire logic        rsp_out_valid,
   input  wire logic [7:0]  rsp_out_char,
   input  wire logic [2:0]  rsp_error_code,
   input  wire logic        rsp_overflow_out,
   input  wire logic        rsp_compare_out,
   output int               fail_count,
   output int               pending_count
);
   typedef struct packed {
      logic [23:0] next_pc;
      logic        halted;
      logic        out_valid;
      logic [7:0]  out_char;
      logic [2:0]  error_code;
      logic        overflow;
      logic        compare;
   } outcome_type;

   // machine state mirror
   logic [23:0] pc;
   logic [15:0] regs [8];
   logic        ovf, cmp;
   logic [7:0]  mem [sbce_pkg::DataBytes];
   logic [15:0] vstack [sbce_pkg::StackDepth];
   int          vsp;
   logic [15:0] fregs [sbce_pkg::FrameDepth*8];
   logic [23:0] fpc [sbce_pkg::FrameDepth];
   logic [1:0]  fflags [sbce_pkg::FrameDepth];
   int          fp;
   outcome_type expected_outcomes [$];

   function automatic int mem_index(logic [23:0] base, int offs);
      logic [23:0] ea;
      ea = base + {{8{regs[7][15]}}, regs[7]};
      return (int'(ea) + offs) % sbce_pkg::DataBytes;
   endfunction

   function automatic void set_arith(logic [2:0] d, int exact);
      ovf = (exact < -32768 || exact > 32767);
      regs[d] = exact[15:0];
   endfunction

   function automatic outcome_type execute_instruction(sbce_pkg::opcode_type op,
         logic [2:0] d, logic [2:0] a, logic [2:0] b, logic signed [15:0] imm,
         logic [23:0] addr, logic [7:0] ch);
      outcome_type o;
      logic [23:0] nxt;
      int rd, ra, rb, cnt, q;
      sbce_pkg::error_type err;
      logic [15:0] v;
      nxt = pc + 24'd4;
      rd = $signed(regs[d]); ra = $signed(regs[a]); rb = $signed(regs[b]);
      cnt = regs[b];
      err = sbce_pkg::ERR_NONE;
      o = '0;
      case (op)
         sbce_pkg::OP_HLT: o.halted = 1'b1;
         sbce_pkg::OP_JMP: nxt = addr;
         sbce_pkg::OP_CJMP: if (cmp) nxt = addr;
         sbce_pkg::OP_OJMP: if (ovf) nxt = addr;
         sbce_pkg::OP_CALL: begin
            if (fp >= sbce_pkg::FrameDepth) err = sbce_pkg::ERR_FRAME;
            else begin
               for (int i = 0; i < 8; i++) fregs[fp*8+i] = regs[i];
               fflags[fp] = {cmp, ovf};
               fpc[fp] = nxt;
               fp++;
               nxt = addr;
            end
         end
         sbce_pkg::OP_RET: begin
            if (fp == 0) err = sbce_pkg::ERR_FRAME;
            else begin
               fp--;
               for (int i = 0; i < 8; i++) regs[i] = fregs[fp*8+i];
               {cmp, ovf} = fflags[fp];
               nxt = fpc[fp];
            end
         end
         sbce_pkg::OP_PUSH: begin
            if (vsp >= sbce_pkg::StackDepth) err = sbce_pkg::ERR_STACK;
            else begin vstack[vsp] = regs[d]; vsp++; end
         end
         sbce_pkg::OP_POP: begin
            if (d == 0) err = sbce_pkg::ERR_POP_R0;
            else if (vsp == 0) err = sbce_pkg::ERR_STACK;
            else begin vsp--; regs[d] = vstack[vsp]; end
         end
         sbce_pkg::OP_LOADB:
            regs[d] = {{8{mem[mem_index(addr, 0)][7]}}, mem[mem_index(addr, 0)]};
         sbce_pkg::OP_LOADW:
            regs[d] = {mem[mem_index(addr, 1)], mem[mem_index(addr, 0)]};
         sbce_pkg::OP_STOREB: mem[mem_index(addr, 0)] = regs[d][7:0];
         sbce_pkg::OP_STOREW: begin
            mem[mem_index(addr, 0)] = regs[d][7:0];
            mem[mem_index(addr, 1)] = regs[d][15:8];
         end
         sbce_pkg::OP_LOADI: regs[d] = imm;
         sbce_pkg::OP_NOP: ;
         sbce_pkg::OP_IN: regs[d] = {8'd0, ch};
         sbce_pkg::OP_OUT: begin o.out_valid = 1'b1; o.out_char = regs[d][7:0]; end
         sbce_pkg::OP_ADD: set_arith(d, ra + rb);
         sbce_pkg::OP_ADDI: set_arith(d, rd + int'(imm));
         sbce_pkg::OP_SUB: set_arith(d, ra - rb);
         sbce_pkg::OP_SUBI: set_arith(d, rd - int'(imm));
         sbce_pkg::OP_MUL: set_arith(d, ra * rb);
         sbce_pkg::OP_DIV: begin
            if (rb == 0) err = sbce_pkg::ERR_DIV_ZERO;
            else begin q = ra / rb; regs[d] = q[15:0]; end
         end
         sbce_pkg::OP_AND: regs[d] = regs[a] & regs[b];
         sbce_pkg::OP_OR:  regs[d] = regs[a] | regs[b];
         sbce_pkg::OP_XOR: regs[d] = regs[a] ^ regs[b];
         sbce_pkg::OP_NOT: regs[d] = ~regs[a];
         sbce_pkg::OP_SAL: regs[d] = (cnt >= 16) ? 16'd0 : regs[a] << cnt;
         sbce_pkg::OP_SAR: begin
            v = regs[a];
            regs[d] = $signed(v) >>> ((cnt >= 16) ? 15 : cnt);
         end
         sbce_pkg::OP_EQU: cmp = (rd == ra);
         sbce_pkg::OP_LT:  cmp = (rd < ra);
         sbce_pkg::OP_LTE: cmp = (rd <= ra);
         default: cmp = ~cmp;
      endcase
      if (err != sbce_pkg::ERR_NONE) o.halted = 1'b1;
      pc = nxt;
      o.next_pc = pc;
      o.error_code = err;
      o.overflow = ovf;
      o.compare = cmp;
      return o;
   endfunction

   // predict on request, compare on response
   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         pc = '0; ovf = 1'b0; cmp = 1'b0; vsp = 0; fp = 0;
         for (int i = 0; i < 8; i++) regs[i] = '0;
         expected_outcomes.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_outcomes.push_back(execute_instruction(
               sbce_pkg::opcode_type'(req_opcode), req_dest_reg, req_src_reg_a,
               req_src_reg_b, req_immediate, req_address, req_in_char));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_next_pc, rsp_halted, rsp_out_valid, rsp_out_char,
                    rsp_error_code, rsp_overflow_out, rsp_compare_out};
            if (expected_outcomes.size() == 0) begin
               $display("%0t: response with no request waiting: %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_outcomes.pop_front();
               if (got != want) begin
                  $display({"%0t: mismatch expected pc=%h halt=%b ov=%b oc=%h",
                            " err=%0d ovf=%b cmp=%b"},
                     $time, want.next_pc, want.halted, want.out_valid, want.out_char,
                     want.error_code, want.overflow, want.compare);
                  $display({"%0t:          actual   pc=%h halt=%b ov=%b oc=%h",
                            " err=%0d ovf=%b cmp=%b"},
                     $time, got.next_pc, got.halted, got.out_valid, got.out_char,
                     got.error_code, got.overflow, got.compare);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_outcomes.size();
   end
endmodule
`default_nettype wire

[tb/sv/sixteen_bit_cpu_execute_test.sv]
// Testbench top: drives instruction requests into the execute stage and gives the verdict.
`default_nettype none
module sixteen_bit_cpu_execute_test;
   localparam int WatchdogLimit = 20000;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [4:0]  req_opcode;
   logic [2:0]  req_dest_reg, req_src_reg_a, req_src_reg_b;
   logic signed [15:0] req_immediate;
   logic [23:0] req_address;
   logic [7:0]  req_in_char;
   logic        rsp_valid, rsp_stall;
   logic [23:0] rsp_next_pc;
   logic        rsp_halted, rsp_out_valid;
   logic [7:0]  rsp_out_char;
   logic [2:0]  rsp_error_code;
   logic        rsp_overflow_out, rsp_compare_out;
   int          fail_count, pending_count, quiet_cycles;
   bit          calm;

   // occupancy mirror, so the stimulus never reads an unwritten store entry
   int          stack_fill, frame_fill;
   bit          written [sbce_pkg::DataBytes];
   logic [15:0] r7_shadow;
   bit          r7_known;

   sixteen_bit_cpu_execute DUT (.*);

   sixteen_bit_cpu_execute_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // stall the response side in bursts
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         n = int'($urandom_range(1, 8));
         if (!calm && $urandom_range(0, 2) == 0) rsp_stall <= 1'b1;
         else rsp_stall <= 1'b0;
         repeat (n) @(posedge clock);
      end
   end

   // watchdog: count cycles without any accepted request or response
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchdogLimit) begin
         $display("sixteen_bit_cpu_execute verification failed");
         $finish;
      end
   end

   // send one request and wait for it to be taken
   task automatic issue(sbce_pkg::opcode_type op, int d, int a, int b, int imm,
         int addr, int ch);
      req_valid <= 1'b1;
      req_opcode <= op; req_dest_reg <= 3'(d); req_src_reg_a <= 3'(a);
      req_src_reg_b <= 3'(b); req_immediate <= 16'(imm); req_address <= 24'(addr);
      req_in_char <= 8'(ch);
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // pick an instruction whose store reads are all of written entries
   task automatic random_instruction(bit use_small_addr);
      sbce_pkg::opcode_type op;
      logic [2:0] d, a, b;
      logic [23:0] addr;
      logic [15:0] imm;
      int base;
      op = sbce_pkg::opcode_type'($urandom_range(0, 31));
      d = 3'($urandom_range(0, 7)); a = 3'($urandom_range(0, 7));
      b = 3'($urandom_range(0, 7));
      imm = 16'($urandom);
      addr = use_small_addr ? 24'($urandom_range(0, 63)) : 24'($urandom);
      // keep r7 out of the way when its value is unknown; data ops then fall back
      if ((op == sbce_pkg::OP_LOADB || op == sbce_pkg::OP_LOADW) && !r7_known)
         op = sbce_pkg::OP_NOP;
      if (op == sbce_pkg::OP_LOADB || op == sbce_pkg::OP_LOADW) begin
         base = (int'(24'(addr + {{8{r7_shadow[15]}}, r7_shadow}))) % sbce_pkg::DataBytes;
         if (!written[base] || (op == sbce_pkg::OP_LOADW &&
               !written[(base + 1) % sbce_pkg::DataBytes]))
            op = sbce_pkg::OP_STOREW;
      end
      if ((op == sbce_pkg::OP_STOREB || op == sbce_pkg::OP_STOREW) && !r7_known)
         op = sbce_pkg::OP_NOP;
      if (op == sbce_pkg::OP_STOREB || op == sbce_pkg::OP_STOREW) begin
         base = (int'(24'(addr + {{8{r7_shadow[15]}}, r7_shadow}))) % sbce_pkg::DataBytes;
         written[base] = 1'b1;
         if (op == sbce_pkg::OP_STOREW) written[(base + 1) % sbce_pkg::DataBytes] = 1'b1;
      end
      if (op == sbce_pkg::OP_POP && d != 0 && stack_fill == 0) op = sbce_pkg::OP_PUSH;
      if (op == sbce_pkg::OP_PUSH && stack_fill < sbce_pkg::StackDepth) stack_fill++;
      if (op == sbce_pkg::OP_POP && d != 0) stack_fill--;
      if (op == sbce_pkg::OP_RET && frame_fill == 0) op = sbce_pkg::OP_CALL;
      if (op == sbce_pkg::OP_CALL && frame_fill < sbce_pkg::FrameDepth) frame_fill++;
      else if (op == sbce_pkg::OP_RET) frame_fill--;
      // r7 is only tracked through LOADI; any other write makes it unknown
      if (d == 3'd7 && !(op inside {sbce_pkg::OP_HLT, sbce_pkg::OP_JMP,
            sbce_pkg::OP_CJMP, sbce_pkg::OP_OJMP, sbce_pkg::OP_CALL, sbce_pkg::OP_RET,
            sbce_pkg::OP_PUSH, sbce_pkg::OP_STOREB, sbce_pkg::OP_STOREW,
            sbce_pkg::OP_NOP, sbce_pkg::OP_OUT, sbce_pkg::OP_EQU, sbce_pkg::OP_LT,
            sbce_pkg::OP_LTE, sbce_pkg::OP_NOTC})) begin
         if (op == sbce_pkg::OP_LOADI) begin r7_shadow = imm; r7_known = 1'b1; end
         else r7_known = 1'b0;
      end
      if (op == sbce_pkg::OP_RET || op == sbce_pkg::OP_CALL) r7_known = 1'b0;
      issue(op, int'(d), int'(a), int'(b), int'(imm), int'(addr),
            int'($urandom_range(0, 255)));
   endtask

   initial begin
      reset = 1'b1; req_valid = 1'b0; calm = 1'b0;
      req_opcode = sbce_pkg::OP_NOP; req_dest_reg = '0; req_src_reg_a = '0;
      req_src_reg_b = '0; req_immediate = '0; req_address = '0; req_in_char = '0;
      stack_fill = 0; frame_fill = 0; r7_shadow = '0; r7_known = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, overflow, divide, shifts, errors
      issue(sbce_pkg::OP_LOADI, 1, 0, 0, 16'h7fff, 0, 0);
      issue(sbce_pkg::OP_LOADI, 2, 0, 0, 16'h8000, 0, 0);
      issue(sbce_pkg::OP_LOADI, 3, 0, 0, 16'hffff, 0, 0);
      issue(sbce_pkg::OP_ADD,   4, 1, 1, 0, 0, 0);
      issue(sbce_pkg::OP_SUB,   4, 2, 1, 0, 0, 0);
      issue(sbce_pkg::OP_MUL,   4, 2, 3, 0, 0, 0);
      issue(sbce_pkg::OP_DIV,   4, 2, 3, 0, 0, 0);
      issue(sbce_pkg::OP_DIV,   4, 1, 0, 0, 0, 0);
      issue(sbce_pkg::OP_ADDI,  1, 0, 0, 16'h7fff, 0, 0);
      issue(sbce_pkg::OP_SUBI,  2, 0, 0, 16'h7fff, 0, 0);
      issue(sbce_pkg::OP_IN,    5, 0, 0, 0, 0, 8'hff);
      issue(sbce_pkg::OP_SAL,   6, 3, 5, 0, 0, 0);
      issue(sbce_pkg::OP_SAR,   6, 2, 5, 0, 0, 0);
      issue(sbce_pkg::OP_OUT,   5, 0, 0, 0, 0, 0);
      issue(sbce_pkg::OP_POP,   0, 0, 0, 0, 0, 0);
      issue(sbce_pkg::OP_POP,   1, 0, 0, 0, 0, 0);
      issue(sbce_pkg::OP_RET,   0, 0, 0, 0, 0, 0);
      issue(sbce_pkg::OP_STOREW, 3, 0, 0, 0, 24'hffffff, 0);
      issue(sbce_pkg::OP_LOADW, 4, 0, 0, 0, 24'hffffff, 0);
      issue(sbce_pkg::OP_LOADB, 4, 0, 0, 0, 24'hffffff, 0);
      issue(sbce_pkg::OP_HLT,   0, 0, 0, 0, 24'hffffff, 0);
      issue(sbce_pkg::OP_JMP,   0, 0, 0, 0, 24'hfffffc, 0);
      issue(sbce_pkg::OP_NOTC,  0, 0, 0, 0, 0, 0);
      issue(sbce_pkg::OP_CJMP,  0, 0, 0, 0, 24'h000100, 0);
      issue(sbce_pkg::OP_OJMP,  0, 0, 0, 0, 24'h000200, 0);
      // the word store at the top of memory wraps its high byte to address 0
      written[16'hffff] = 1'b1; written[16'h0000] = 1'b1;
      r7_shadow = '0; r7_known = 1'b1;

      // fill both stacks to their limits and one beyond, then drain the frame stack past empty
      for (int i = 0; i < sbce_pkg::FrameDepth + 1; i++)
         issue(sbce_pkg::OP_CALL, 0, 0, 0, 0, int'($urandom_range(0, 16777215)), 0);
      for (int i = 0; i < sbce_pkg::FrameDepth + 1; i++)
         issue(sbce_pkg::OP_RET, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < sbce_pkg::StackDepth + 1; i++)
         issue(sbce_pkg::OP_PUSH, int'($urandom_range(0, 7)), 0, 0, 0, 0, 0);
      stack_fill = sbce_pkg::StackDepth;
      frame_fill = 0;
      r7_known = 1'b0;
      issue(sbce_pkg::OP_LOADI, 7, 0, 0, 16'h0000, 0, 0);
      r7_known = 1'b1; r7_shadow = '0;

      // random: mostly small addresses so loads find written bytes
      for (int i = 0; i < 700; i++) begin
         if (i == 600) calm = 1'b1;
         random_instruction($urandom_range(0, 9) != 0);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      wait (pending_count == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("sixteen_bit_cpu_execute verification clean");
      else $display("sixteen_bit_cpu_execute verification failed");
      $finish;
   end
endmodule
`default_nettype wire
